// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions on the clock and reset of a block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define PBBA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define PBBA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/pbba_pkg.sv =====
// ----------------------------------------------------------------------------
// Port block bitmap allocator package
// Request codes, register indices, controller states and bit search helper.
// ----------------------------------------------------------------------------
package pbba_pkg;

   localparam int BITS_PER_WORD = 64;
   localparam int BIT_W         = 6;
   localparam int PORT_W        = 16;
   localparam int BLK_W         = 11;
   localparam int DRAW_WORD_W   = PORT_W - BIT_W;

   typedef enum logic [1:0] {
      MODE_FIRST    = 2'd0,
      MODE_RANDOM   = 2'd1,
      MODE_SPECIFIC = 2'd2,
      MODE_RELEASE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CSR_FIRST_PORT  = 2'd0,
      CSR_BLOCK_PORTS = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_TAKE,
      ST_REL,
      ST_SCAN
   } state_type;

   // Index of the lowest clear bit; only meaningful when a clear bit exists.
   function automatic logic [BIT_W-1:0] lowest_clear(input logic [BITS_PER_WORD-1:0] w);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = BITS_PER_WORD - 1; i >= 0; i--) begin
         if (!w[i]) begin
            idx = BIT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== hw/rtl/pbba_bitmap_mem.sv =====
// ----------------------------------------------------------------------------
// Bitmap memory
// One write and one registered read per cycle; per-entry valid bits make an
// entry read as all-free until it is first written.
// ----------------------------------------------------------------------------
module pbba_bitmap_mem #(
   parameter int DEPTH = 48,
   parameter int AW    = 6
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               rd_en,
   input  logic [AW-1:0]                      rd_addr,
   output logic [pbba_pkg::BITS_PER_WORD-1:0] rd_data,
   input  logic                               wr_en,
   input  logic [AW-1:0]                      wr_addr,
   input  logic [pbba_pkg::BITS_PER_WORD-1:0] wr_data
);
   import pbba_pkg::*;

   logic [BITS_PER_WORD-1:0] mem [DEPTH];
   logic [DEPTH-1:0]         vld_ff;
   logic [BITS_PER_WORD-1:0] rd_data_ff;
   logic                     rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

// ===== hw/rtl/pbba_mod_unit.sv =====
// ----------------------------------------------------------------------------
// Modulo unit
// Restoring remainder of the draw's word number by the word count, two
// quotient bits per cycle.
// ----------------------------------------------------------------------------
module pbba_mod_unit #(
   parameter int WCW = 5
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [pbba_pkg::DRAW_WORD_W-1:0] dividend,
   input  logic [WCW-1:0]                   divisor,
   output logic                             done,
   output logic [WCW-1:0]                   remainder
);
   import pbba_pkg::*;

   localparam int STEP_BITS = 2;
   localparam int ITER      = (DRAW_WORD_W + STEP_BITS - 1) / STEP_BITS;
   localparam int CNT_W     = $clog2(ITER + 1);

   logic                   run_ff;
   logic                   done_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic [DRAW_WORD_W-1:0] dvd_ff;
   logic [DRAW_WORD_W-1:0] dvd_in;
   logic [WCW-1:0]         dvs_ff;
   logic [WCW-1:0]         rem_ff;
   logic [WCW-1:0]         rem_in;

   always_comb begin
      logic [WCW-1:0]         r;
      logic [WCW:0]           r2;
      logic [DRAW_WORD_W-1:0] d;
      r = rem_ff;
      d = dvd_ff;
      for (int k = 0; k < STEP_BITS; k++) begin
         r2 = {r, d[DRAW_WORD_W-1]};
         d  = {d[DRAW_WORD_W-2:0], 1'b0};
         if (r2 >= {1'b0, dvs_ff}) begin
            r2 = r2 - {1'b0, dvs_ff};
         end
         r = r2[WCW-1:0];
      end
      rem_in = r;
      dvd_in = d;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
            dvd_ff <= dividend;
            dvs_ff <= divisor;
            rem_ff <= '0;
         end else if (run_ff) begin
            rem_ff <= rem_in;
            dvd_ff <= dvd_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ITER - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== hw/rtl/port_block_bitmap_allocator.sv =====
// A request refused up front is answered straight from idle; specific and release read
// the word, then write and answer. First-free scans one bitmap word read per cycle; random
// runs the modulo unit, then takes the drawn port or falls back to a scan.
// One request at a time; a new one is taken in the cycle its result is shown.
// Results cannot be stalled. Synchronous reset frees every port at once.
// ----------------------------------------------------------------------------
// Port block bitmap allocator
// Per-protocol port bitmaps in one memory, read-modify-write controller with
// first-free scan, random pick, specific take and release.
// ----------------------------------------------------------------------------
module port_block_bitmap_allocator #(
   parameter int MAX_WORDS     = 16,
   parameter int PROTO_CLASSES = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [1:0]  req_proto,
   input  logic [15:0] req_port,
   input  logic [15:0] req_random_draw,
   output logic        rsp_valid,
   output logic [15:0] rsp_result_port,
   output logic        rsp_success,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import pbba_pkg::*;

   localparam int WW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int WCW   = $clog2(MAX_WORDS + 1);
   localparam int NPW   = WCW + BIT_W;
   localparam int CW    = $clog2(MAX_WORDS * BITS_PER_WORD + 1);
   localparam int PW    = (PROTO_CLASSES > 1) ? $clog2(PROTO_CLASSES) : 1;
   localparam int DEPTH = PROTO_CLASSES * MAX_WORDS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [1:0] PROTO_LIM = 2'(PROTO_CLASSES);

   function automatic logic [AW-1:0] word_addr(input logic [PW-1:0] p,
                                                input logic [WW-1:0] w);
      return AW'(int'(p) * MAX_WORDS + int'(w));
   endfunction

   // configuration
   logic [PORT_W-1:0] csr_first_port_ff;
   logic [BLK_W-1:0]  csr_block_ports_ff;

   // controller
   state_type          state_ff, state_in;
   mode_type           mode_ff, mode_in;
   logic [PW-1:0]      proto_ff, proto_in;
   logic [WW-1:0]      tgt_word_ff, tgt_word_in;
   logic [BIT_W-1:0]   tgt_bit_ff, tgt_bit_in;
   logic [WW-1:0]      scan_w_ff, scan_w_in;
   logic [WW-1:0]      pend_w_ff, pend_w_in;
   logic               pend_ff, pend_in;
   logic [WCW-1:0]     issued_ff, issued_in;
   logic [WCW-1:0]     checked_ff, checked_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PORT_W-1:0]  rsp_port_ff, rsp_port_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [CW-1:0]      used_cnt_ff [PROTO_CLASSES];
   logic [CW-1:0]      used_cnt_in [PROTO_CLASSES];
   logic [WW-1:0]      scan_word_ff [PROTO_CLASSES];
   logic [WW-1:0]      scan_word_in [PROTO_CLASSES];

   // memory and modulo unit
   logic                     mem_rd_en;
   logic [AW-1:0]            mem_rd_addr;
   logic [BITS_PER_WORD-1:0] mem_rd_data;
   logic                     mem_wr_en;
   logic [AW-1:0]            mem_wr_addr;
   logic [BITS_PER_WORD-1:0] mem_wr_data;
   logic                     mod_start;
   logic                     mod_done;
   logic [WCW-1:0]           mod_rem;

   // block geometry
   logic [BLK_W-BIT_W-1:0] blk_words;
   logic [WCW-1:0]         wc;
   logic [NPW-1:0]         nports;
   logic                   blk_ok;
   logic [PW-1:0]          req_p;
   logic                   req_proto_ok;
   logic [PORT_W-1:0]      req_off;
   logic                   req_in_blk;
   logic                   req_full;
   logic                   accept;

   assign blk_words = csr_block_ports_ff[BLK_W-1:BIT_W];
   assign wc        = (int'(blk_words) > MAX_WORDS) ? WCW'(MAX_WORDS) : WCW'(blk_words);
   assign nports    = {wc, {BIT_W{1'b0}}};
   assign blk_ok    = (wc != '0) &&
                      ((18'(csr_first_port_ff) + 18'(nports)) <= 18'h10000);

   assign req_p        = req_proto[PW-1:0];
   assign req_proto_ok = req_proto < PROTO_LIM;
   assign req_off      = req_port - csr_first_port_ff;
   assign req_in_blk   = (req_port >= csr_first_port_ff) && (18'(req_off) < 18'(nports));
   assign req_full     = 18'(used_cnt_ff[req_p]) == 18'(nports);

   assign busy   = state_ff != ST_IDLE;
   assign accept = start && !busy;

   pbba_bitmap_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   pbba_mod_unit #(
      .WCW (WCW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (req_random_draw[PORT_W-1:BIT_W]),
      .divisor   (wc),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_comb begin
      logic                     hit_bit;
      logic [BITS_PER_WORD-1:0] tgt_mask;
      logic [BIT_W-1:0]         free_bit;
      logic [CW-1:0]            cur_cnt;

      state_in     = state_ff;
      mode_in      = mode_ff;
      proto_in     = proto_ff;
      tgt_word_in  = tgt_word_ff;
      tgt_bit_in   = tgt_bit_ff;
      scan_w_in    = scan_w_ff;
      pend_w_in    = pend_w_ff;
      pend_in      = pend_ff;
      issued_in    = issued_ff;
      checked_in   = checked_ff;
      rsp_valid_in = 1'b0;
      rsp_port_in  = rsp_port_ff;
      rsp_ok_in    = rsp_ok_ff;
      used_cnt_in  = used_cnt_ff;
      scan_word_in = scan_word_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = '0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = '0;
      mem_wr_data  = '0;
      mod_start    = 1'b0;

      hit_bit  = mem_rd_data[tgt_bit_ff];
      tgt_mask = BITS_PER_WORD'(1) << tgt_bit_ff;
      free_bit = lowest_clear(mem_rd_data);
      cur_cnt  = used_cnt_ff[proto_ff];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in     = mode_type'(req_mode);
               proto_in    = req_p;
               tgt_word_in = req_off[BIT_W +: WW];
               tgt_bit_in  = (mode_type'(req_mode) == MODE_RANDOM) ?
                             req_random_draw[BIT_W-1:0] : req_off[BIT_W-1:0];
               // refuse up front unless a later state takes over
               rsp_valid_in = 1'b1;
               rsp_port_in  = '0;
               rsp_ok_in    = 1'b0;
               if (req_proto_ok && blk_ok) begin
                  case (mode_type'(req_mode))
                     MODE_RELEASE: begin
                        if (req_in_blk) begin
                           rsp_valid_in = 1'b0;
                           mem_rd_en    = 1'b1;
                           mem_rd_addr  = word_addr(req_p, req_off[BIT_W +: WW]);
                           state_in     = ST_REL;
                        end
                     end
                     MODE_FIRST: begin
                        if (!req_full) begin
                           rsp_valid_in = 1'b0;
                           scan_w_in    = (WCW'(scan_word_ff[req_p]) >= wc) ?
                                          '0 : scan_word_ff[req_p];
                           issued_in    = '0;
                           checked_in   = '0;
                           pend_in      = 1'b0;
                           state_in     = ST_SCAN;
                        end
                     end
                     MODE_RANDOM: begin
                        if (!req_full) begin
                           rsp_valid_in = 1'b0;
                           mod_start    = 1'b1;
                           state_in     = ST_MOD;
                        end
                     end
                     MODE_SPECIFIC: begin
                        if (!req_full && req_in_blk) begin
                           rsp_valid_in = 1'b0;
                           mem_rd_en    = 1'b1;
                           mem_rd_addr  = word_addr(req_p, req_off[BIT_W +: WW]);
                           state_in     = ST_TAKE;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end

         ST_MOD: begin
            if (mod_done) begin
               tgt_word_in = WW'(mod_rem);
               mem_rd_en   = 1'b1;
               mem_rd_addr = word_addr(proto_ff, WW'(mod_rem));
               state_in    = ST_TAKE;
            end
         end

         ST_TAKE: begin
            if (!hit_bit) begin
               mem_wr_en             = 1'b1;
               mem_wr_addr           = word_addr(proto_ff, tgt_word_ff);
               mem_wr_data           = mem_rd_data | tgt_mask;
               used_cnt_in[proto_ff] = CW'(cur_cnt + 1'b1);
               rsp_valid_in          = 1'b1;
               rsp_port_in           = csr_first_port_ff + PORT_W'({tgt_word_ff, tgt_bit_ff});
               rsp_ok_in             = 1'b1;
               state_in              = ST_IDLE;
            end else if (mode_ff == MODE_RANDOM) begin
               // drawn port taken: scan on from the draw's word
               scan_word_in[proto_ff] = tgt_word_ff;
               scan_w_in              = tgt_word_ff;
               issued_in              = '0;
               checked_in             = '0;
               pend_in                = 1'b0;
               state_in               = ST_SCAN;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_port_in  = '0;
               rsp_ok_in    = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         ST_REL: begin
            rsp_valid_in = 1'b1;
            rsp_port_in  = '0;
            rsp_ok_in    = hit_bit;
            state_in     = ST_IDLE;
            if (hit_bit) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = word_addr(proto_ff, tgt_word_ff);
               mem_wr_data = mem_rd_data & ~tgt_mask;
               if (cur_cnt != '0) begin
                  used_cnt_in[proto_ff] = cur_cnt - 1'b1;
               end
            end
         end

         ST_SCAN: begin
            if (pend_ff && (mem_rd_data != '1)) begin
               mem_wr_en              = 1'b1;
               mem_wr_addr            = word_addr(proto_ff, pend_w_ff);
               mem_wr_data            = mem_rd_data | (BITS_PER_WORD'(1) << free_bit);
               used_cnt_in[proto_ff]  = CW'(cur_cnt + 1'b1);
               scan_word_in[proto_ff] = pend_w_ff;
               rsp_valid_in           = 1'b1;
               rsp_port_in            = csr_first_port_ff + PORT_W'({pend_w_ff, free_bit});
               rsp_ok_in              = 1'b1;
               state_in               = ST_IDLE;
            end else if (pend_ff && (WCW'(checked_ff + 1'b1) == wc)) begin
               rsp_valid_in = 1'b1;
               rsp_port_in  = '0;
               rsp_ok_in    = 1'b0;
               state_in     = ST_IDLE;
            end else begin
               // issue the next word while the previous one is checked
               checked_in = checked_ff + WCW'(pend_ff);
               pend_in    = 1'b0;
               if (issued_ff != wc) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = word_addr(proto_ff, scan_w_ff);
                  pend_in     = 1'b1;
                  pend_w_in   = scan_w_ff;
                  issued_in   = issued_ff + 1'b1;
                  scan_w_in   = (WCW'(WCW'(scan_w_ff) + 1'b1) == wc) ?
                                '0 : WW'(scan_w_ff + 1'b1);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         rsp_valid_ff       <= 1'b0;
         pend_ff            <= 1'b0;
         issued_ff          <= '0;
         checked_ff         <= '0;
         csr_first_port_ff  <= 16'd1024;
         csr_block_ports_ff <= 11'd128;
         for (int i = 0; i < PROTO_CLASSES; i++) begin
            used_cnt_ff[i]  <= '0;
            scan_word_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         issued_ff    <= issued_in;
         checked_ff   <= checked_in;
         used_cnt_ff  <= used_cnt_in;
         scan_word_ff <= scan_word_in;
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_FIRST_PORT:  csr_first_port_ff  <= csr_wdata;
               CSR_BLOCK_PORTS: csr_block_ports_ff <= csr_wdata[BLK_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      proto_ff    <= proto_in;
      tgt_word_ff <= tgt_word_in;
      tgt_bit_ff  <= tgt_bit_in;
      scan_w_ff   <= scan_w_in;
      pend_w_ff   <= pend_w_in;
      rsp_port_ff <= rsp_port_in;
      rsp_ok_ff   <= rsp_ok_in;
   end

   assign csr_ready       = !busy;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_port = rsp_port_ff;
   assign rsp_success     = rsp_ok_ff;

endmodule

// ===== hw/rtl/pbba_checker.sv =====
// ----------------------------------------------------------------------------
// Port block bitmap allocator checker
// Port-level properties of the request and result channels, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pbba_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [15:0] rsp_result_port,
   input logic        rsp_success
);

   // a failed transaction never reports a port
   `PBBA_ASSERT(a_fail_port_zero, rsp_valid && !rsp_success |-> rsp_result_port == 16'd0, "failed transaction carries a port")

   // an accepted transaction either keeps the block busy or answers at once
   `PBBA_ASSERT(a_accept_progress, start && !busy |=> busy || rsp_valid, "accepted transaction dropped")

   // a result only follows work in progress or an acceptance
   `PBBA_ASSERT(a_no_spurious_rsp, rsp_valid |-> $past(busy) || $past(start), "result without a transaction")

   // reset leaves the block idle and silent
   `PBBA_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid && !busy, "activity after reset")

endmodule

bind port_block_bitmap_allocator pbba_checker u_pbba_checker (.*);
